// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file msort_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset
`define MSORT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked in every cycle, reset included
`define MSORT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/msort_pkg.sv =====
`default_nettype none
package msort_pkg;

  // element width and default capacity
  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

// ===== rtl/msort_if.sv =====
`default_nettype none
// Input channel: one element per word
interface msort_in_if;
  import msort_pkg::*;
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Result channel: one sorted element per word
interface msort_out_if;
  import msort_pkg::*;
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  end_of_run;
  logic  overflow;

  modport source (output valid, output sorted_value, output end_of_run, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, input overflow,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/msort_ram.sv =====
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle
module msort_ram #(
  parameter int WIDTH = msort_pkg::DATA_W,
  parameter int DEPTH = msort_pkg::MAX_ITEMS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/merge_sorter_core.sv =====
// Load: one input word per cycle; the word marked last starts the sort (emit if n < 2).
// Sort: ceil(log2 n) passes; each run pair reads its heads in ST_HEAD_A, ST_HEAD_B,
//   then ST_MERGE; heads are refilled one read per cycle by the source RAM's read port.
// Emit: read stage, then output register; one word per cycle unless the output stalls.
// Reset: synchronous, active low; clears control and cnt_r, RAM contents undefined.
`default_nettype none
module merge_sorter_core #(
  parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  msort_in_if.sink     in_ch,
  msort_out_if.source  out_ch
);
  import msort_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_HEAD_A = 5'b00010,
    ST_HEAD_B = 5'b00100,
    ST_MERGE  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           par_r, par_nxt;        // 0: source is ram0, 1: source is ram1
  logic [PW-1:0]  width_r, width_nxt;
  logic [PW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  mid_r, mid_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  data_t          head_i_r, head_i_nxt;
  data_t          head_j_r, head_j_nxt;
  logic           pend_i_r, pend_i_nxt;
  logic           pend_j_r, pend_j_nxt;
  logic           rd_v_r, rd_v_nxt;
  logic           rd_last_r, rd_last_nxt;
  logic           out_v_r, out_v_nxt;
  data_t          out_val_r, out_val_nxt;
  logic           out_end_r, out_end_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  // RAM access
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic           wr_ram0;
  logic [AW-1:0]  wr_addr;
  data_t          wr_data;
  data_t          ram0_rdata, ram1_rdata, rd_data;

  // datapath helpers
  logic           store_ok;
  logic [CW-1:0]  cnt_inc, n_load;
  logic [PW:0]    n_ext, mid_sum, hi_sum;
  logic [CW-1:0]  mid_c, hi_c;
  logic [PW-1:0]  wide2;
  logic           done_pass, last_pass;
  logic [CW-1:0]  i_inc, j_inc, k_inc;
  data_t          hv_i, hv_j;
  logic           avail_i, avail_j, take_i;
  logic           load_out;

  msort_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram0 (
    .clk   (clk),
    .we    (wr_en && wr_ram0),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && !par_r),
    .raddr (rd_addr),
    .rdata (ram0_rdata)
  );

  msort_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram1 (
    .clk   (clk),
    .we    (wr_en && !wr_ram0),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && par_r),
    .raddr (rd_addr),
    .rdata (ram1_rdata)
  );

  assign rd_data = par_r ? ram1_rdata : ram0_rdata;

  // load bookkeeping
  assign store_ok = (cnt_r < MAX_CNT);
  assign cnt_inc  = cnt_r + CW'(1);
  assign n_load   = store_ok ? cnt_inc : cnt_r;

  // run bounds of the current pair, clamped to the element count
  assign n_ext     = (PW+1)'(cnt_r);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, width_r};
  assign hi_sum    = {1'b0, lo_r} + {width_r, 1'b0};
  assign mid_c     = (mid_sum > n_ext) ? cnt_r : mid_sum[CW-1:0];
  assign hi_c      = (hi_sum > n_ext) ? cnt_r : hi_sum[CW-1:0];
  assign done_pass = (hi_sum >= n_ext);
  assign wide2     = {width_r[PW-2:0], 1'b0};
  assign last_pass = (wide2 >= PW'(cnt_r));

  // merge compare on the current run heads; a pending read supplies a fresh head
  assign i_inc   = i_r + CW'(1);
  assign j_inc   = j_r + CW'(1);
  assign k_inc   = k_r + CW'(1);
  assign hv_i    = pend_i_r ? rd_data : head_i_r;
  assign hv_j    = pend_j_r ? rd_data : head_j_r;
  assign avail_i = (i_r < mid_r);
  assign avail_j = (j_r < hi_r);
  assign take_i  = avail_i && (!avail_j || (hv_i <= hv_j));

  // read stage moves into the output register when that is free
  assign load_out = rd_v_r && (!out_v_r || out_ch.ready);

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign out_ch.valid        = out_v_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.end_of_run   = out_end_r;
  assign out_ch.overflow     = out_ovf_r;

  // control and sequencing
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    par_nxt     = par_r;
    width_nxt   = width_r;
    lo_nxt      = lo_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    head_i_nxt  = head_i_r;
    head_j_nxt  = head_j_r;
    pend_i_nxt  = pend_i_r;
    pend_j_nxt  = pend_j_r;
    rd_v_nxt    = rd_v_r;
    rd_last_nxt = rd_last_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_ram0     = par_r;
    wr_addr     = k_r[AW-1:0];
    wr_data     = take_i ? hv_i : hv_j;

    case (state_r)
      ST_LOAD: begin
        wr_ram0 = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_ch.value;
        if (in_ch.valid) begin
          wr_en   = store_ok;
          cnt_nxt = n_load;
          if (!store_ok) begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) begin
            par_nxt   = 1'b0;
            width_nxt = PW'(1);
            lo_nxt    = '0;
            k_nxt     = '0;
            rd_v_nxt  = 1'b0;
            state_nxt = (n_load > CW'(1)) ? ST_HEAD_A : ST_EMIT;
          end
        end
      end

      ST_HEAD_A: begin
        rd_en      = 1'b1;
        rd_addr    = lo_r[AW-1:0];
        pend_i_nxt = 1'b1;
        pend_j_nxt = 1'b0;
        mid_nxt    = mid_c;
        hi_nxt     = hi_c;
        i_nxt      = lo_r[CW-1:0];
        j_nxt      = mid_c;
        k_nxt      = lo_r[CW-1:0];
        state_nxt  = ST_HEAD_B;
      end

      ST_HEAD_B: begin
        head_i_nxt = rd_data;
        pend_i_nxt = 1'b0;
        if (avail_j) begin
          rd_en      = 1'b1;
          rd_addr    = j_r[AW-1:0];
          pend_j_nxt = 1'b1;
        end
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        wr_en = 1'b1;
        k_nxt = k_inc;
        if (take_i) begin
          i_nxt      = i_inc;
          head_j_nxt = hv_j;
          pend_j_nxt = 1'b0;
          pend_i_nxt = (i_inc < mid_r);
          if (i_inc < mid_r) begin
            rd_en   = 1'b1;
            rd_addr = i_inc[AW-1:0];
          end
        end else begin
          j_nxt      = j_inc;
          head_i_nxt = hv_i;
          pend_i_nxt = 1'b0;
          pend_j_nxt = (j_inc < hi_r);
          if (j_inc < hi_r) begin
            rd_en   = 1'b1;
            rd_addr = j_inc[AW-1:0];
          end
        end
        // pair finished: next pair, next pass, or emit
        if (k_inc == hi_r) begin
          if (done_pass) begin
            lo_nxt    = '0;
            width_nxt = wide2;
            par_nxt   = !par_r;
            if (last_pass) begin
              k_nxt     = '0;
              rd_v_nxt  = 1'b0;
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_HEAD_A;
            end
          end else begin
            lo_nxt    = hi_sum[PW-1:0];
            state_nxt = ST_HEAD_A;
          end
        end
      end

      ST_EMIT: begin
        if ((k_r < cnt_r) && (!rd_v_r || load_out)) begin
          rd_en       = 1'b1;
          rd_addr     = k_r[AW-1:0];
          k_nxt       = k_inc;
          rd_v_nxt    = 1'b1;
          rd_last_nxt = (k_inc == cnt_r);
        end else if (load_out) begin
          rd_v_nxt = 1'b0;
        end
        // final word handed to the output register: ready for the next set
        if (load_out && rd_last_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // output register
  always_comb begin
    out_v_nxt   = out_v_r;
    out_val_nxt = out_val_r;
    out_end_nxt = out_end_r;
    out_ovf_nxt = out_ovf_r;
    if (load_out) begin
      out_v_nxt   = 1'b1;
      out_val_nxt = rd_data;
      out_end_nxt = rd_last_r;
      out_ovf_nxt = ovf_r;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      par_r     <= 1'b0;
      pend_i_r  <= 1'b0;
      pend_j_r  <= 1'b0;
      rd_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      par_r     <= par_nxt;
      pend_i_r  <= pend_i_nxt;
      pend_j_r  <= pend_j_nxt;
      rd_v_r    <= rd_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    width_r   <= width_nxt;
    lo_r      <= lo_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    head_i_r  <= head_i_nxt;
    head_j_r  <= head_j_nxt;
    rd_last_r <= rd_last_nxt;
    out_val_r <= out_val_nxt;
    out_end_r <= out_end_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/msort_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the sorter
module msort_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire msort_pkg::data_t  out_sorted_value,
  input wire logic              out_end_of_run,
  input wire logic              out_overflow
);

  // no result word right after reset
  `MSORT_ASSERT_ALWAYS(a_out_idle_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result word holds
  `MSORT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sorted_value), "stalled result changed")

  // taking the closing word of a set drops in_ready, so no further input is taken
  `MSORT_ASSERT(a_busy_after_last, clk, rst_n, in_valid && in_ready && in_last |=> !in_ready, "input taken while sorting")

  // back-to-back words of one set come in ascending order
  `MSORT_ASSERT(a_ascending, clk, rst_n, out_valid && out_ready && !out_end_of_run |=> !out_valid || (out_sorted_value >= $past(out_sorted_value)), "results out of order")

  // overflow flag is the same on every word of a set
  `MSORT_ASSERT(a_ovf_steady, clk, rst_n, out_valid && out_ready && !out_end_of_run |=> !out_valid || (out_overflow == $past(out_overflow)), "overflow flag changed within a set")

endmodule

bind merge_sorter_core msort_checker u_msort_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last          (in_ch.last),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sorted_value (out_ch.sorted_value),
  .out_end_of_run   (out_ch.end_of_run),
  .out_overflow     (out_ch.overflow)
);
`default_nettype wire
